@@ rtl/cab_pkg.sv @@
// Package for the clipped alpha blitter: sizes, register codes, payload types, helpers.
package cab_pkg;

  // Largest dimensions the datapath supports
  localparam int MAX_SCREEN_WIDTH  = 1024;
  localparam int MAX_SCREEN_HEIGHT = 1024;
  localparam int MAX_TEXTURE_DIM   = 1024;

  // Field widths
  localparam int DIM_W      = 11;
  localparam int POS_W      = 12;
  localparam int CH_W       = 8;
  localparam int ADDR_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Texel counter and derived datapath widths
  localparam int TEX_CNT_W   = $clog2(MAX_TEXTURE_DIM);
  localparam int CNT_CMP_W   = (TEX_CNT_W + 1 > DIM_W) ? TEX_CNT_W + 1 : DIM_W;
  localparam int SX_W        = ((POS_W > TEX_CNT_W + 1) ? POS_W : TEX_CNT_W + 1) + 1;
  localparam int ADDR_FULL_W = (SX_W - 1 + DIM_W > ADDR_W) ? SX_W - 1 + DIM_W : ADDR_W;
  localparam int PROD_W      = 2 * CH_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE    = 3'd6;

  // Register reset values
  localparam int SCREEN_WIDTH_RST  = 1024;
  localparam int SCREEN_HEIGHT_RST = 768;
  localparam int TEX_DIM_RST       = 1;

  // Blend modes
  localparam logic BLEND_OPAQUE = 1'b0;
  localparam logic BLEND_ALPHA  = 1'b1;

  // Input request payload
  typedef struct packed {
    logic [CH_W-1:0] src_ch0;
    logic [CH_W-1:0] src_ch1;
    logic [CH_W-1:0] src_ch2;
    logic [CH_W-1:0] src_alpha;
    logic [CH_W-1:0] dst_ch0;
    logic [CH_W-1:0] dst_ch1;
    logic [CH_W-1:0] dst_ch2;
    logic [CH_W-1:0] dst_ch3;
  } cab_in_t;

  // Result payload
  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] screen_addr;
    logic [CH_W-1:0]   out_ch0;
    logic [CH_W-1:0]   out_ch1;
    logic [CH_W-1:0]   out_ch2;
    logic [CH_W-1:0]   out_ch3;
    logic              last_texel;
  } cab_out_t;

  // Configuration as seen by the datapath (dimensions already clamped)
  typedef struct packed {
    logic [DIM_W-1:0]        screen_width;
    logic [DIM_W-1:0]        screen_height;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [DIM_W-1:0]        tex_width;
    logic [DIM_W-1:0]        tex_height;
    logic                    blend_mode;
  } cab_cfg_t;

  // Texel position that travels with each request
  typedef struct packed {
    logic [TEX_CNT_W-1:0] col;
    logic [TEX_CNT_W-1:0] row;
    logic                 last;
  } cab_cnt_t;

  // Zero acts as one, anything above the limit saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > max_v) begin
      r = DIM_W'(max_v);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/cab_cfg_regs.sv @@
// Configuration register file for the blitter, stores clamped dimensions.
module cab_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cab_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cab_pkg::cab_cfg_t               cfg
);
  import cab_pkg::*;

  cab_cfg_t          cfg_r;
  logic [DIM_W-1:0]  dim_wr;

  // Writes are always accepted
  assign cfg_ready = 1'b1;
  assign dim_wr    = cfg_data[DIM_W-1:0];
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= clamp_dim(DIM_W'(SCREEN_WIDTH_RST), MAX_SCREEN_WIDTH);
      cfg_r.screen_height <= clamp_dim(DIM_W'(SCREEN_HEIGHT_RST), MAX_SCREEN_HEIGHT);
      cfg_r.pos_x         <= '0;
      cfg_r.pos_y         <= '0;
      cfg_r.tex_width     <= clamp_dim(DIM_W'(TEX_DIM_RST), MAX_TEXTURE_DIM);
      cfg_r.tex_height    <= clamp_dim(DIM_W'(TEX_DIM_RST), MAX_TEXTURE_DIM);
      cfg_r.blend_mode    <= BLEND_OPAQUE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= clamp_dim(dim_wr, MAX_SCREEN_WIDTH);
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= clamp_dim(dim_wr, MAX_SCREEN_HEIGHT);
        REG_POS_X:         cfg_r.pos_x         <= $signed(cfg_data[POS_W-1:0]);
        REG_POS_Y:         cfg_r.pos_y         <= $signed(cfg_data[POS_W-1:0]);
        REG_TEX_WIDTH:     cfg_r.tex_width     <= clamp_dim(dim_wr, MAX_TEXTURE_DIM);
        REG_TEX_HEIGHT:    cfg_r.tex_height    <= clamp_dim(dim_wr, MAX_TEXTURE_DIM);
        REG_BLEND_MODE:    cfg_r.blend_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/cab_texel_cnt.sv @@
// Raster-order texel column/row counter with end-of-row and end-of-texture detect.
module cab_texel_cnt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  cab_pkg::cab_cfg_t cfg,
  output cab_pkg::cab_cnt_t cnt
);
  import cab_pkg::*;

  logic [TEX_CNT_W-1:0] col_r, col_nxt;
  logic [TEX_CNT_W-1:0] row_r, row_nxt;
  logic [CNT_CMP_W-1:0] col_inc;
  logic [CNT_CMP_W-1:0] row_inc;
  logic                 row_end;
  logic                 tex_end;

  // End tests use >= so a shrunken texture still wraps
  assign col_inc = CNT_CMP_W'(col_r) + CNT_CMP_W'(1);
  assign row_inc = CNT_CMP_W'(row_r) + CNT_CMP_W'(1);
  assign row_end = col_inc >= CNT_CMP_W'(cfg.tex_width);
  assign tex_end = row_inc >= CNT_CMP_W'(cfg.tex_height);

  assign cnt.col  = col_r;
  assign cnt.row  = row_r;
  assign cnt.last = row_end && tex_end;

  always_comb begin
    col_nxt = col_inc[TEX_CNT_W-1:0];
    row_nxt = row_r;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = tex_end ? '0 : row_inc[TEX_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

`ifndef SYNTHESIS
  // Last texel wraps both counters
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    adv && cnt.last |=> col_r == '0 && row_r == '0)
    else $error("texel counters did not wrap after last texel");

  // Inside a row the column steps by one and the row holds
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !row_end |=> col_r == $past(col_inc[TEX_CNT_W-1:0]) && $stable(row_r))
    else $error("texel column did not step inside a row");
`endif

endmodule

@@ rtl/cab_pixel_calc.sv @@
// Clip, screen address and blend for one texel (combinational).
module cab_pixel_calc (
  input  cab_pkg::cab_in_t  pix,
  input  cab_pkg::cab_cnt_t cnt,
  input  cab_pkg::cab_cfg_t cfg,
  output cab_pkg::cab_out_t res
);
  import cab_pkg::*;

  logic signed [SX_W-1:0]  sx;
  logic signed [SX_W-1:0]  sy;
  logic                    onscreen;
  logic [ADDR_FULL_W-1:0]  row_base;
  logic [ADDR_FULL_W-1:0]  addr_full;
  logic [CH_W-1:0]         src [3];
  logic [CH_W-1:0]         dst [3];
  logic [CH_W-1:0]         mix [3];
  logic                    alpha_zero;
  logic                    alpha_full;

  // Screen position of this texel
  assign sx = SX_W'(cfg.pos_x) + $signed(SX_W'(cnt.col));
  assign sy = SX_W'(cfg.pos_y) + $signed(SX_W'(cnt.row));

  assign onscreen = !sx[SX_W-1] && !sy[SX_W-1] &&
                    (sx[SX_W-2:0] < (SX_W-1)'(cfg.screen_width)) &&
                    (sy[SX_W-2:0] < (SX_W-1)'(cfg.screen_height));

  // Linear address: row * width + column
  assign row_base  = ADDR_FULL_W'(sy[SX_W-2:0]) * ADDR_FULL_W'(cfg.screen_width);
  assign addr_full = row_base + ADDR_FULL_W'(sx[SX_W-2:0]);

  assign src[0] = pix.src_ch0;
  assign src[1] = pix.src_ch1;
  assign src[2] = pix.src_ch2;
  assign dst[0] = pix.dst_ch0;
  assign dst[1] = pix.dst_ch1;
  assign dst[2] = pix.dst_ch2;

  assign alpha_zero = pix.src_alpha == '0;
  assign alpha_full = pix.src_alpha == '1;

  // Per channel: dst + floor(alpha * (src - dst) / 256), low byte only
  for (genvar g = 0; g < 3; g++) begin : g_mix
    logic signed [PROD_W-1:0] prod;
    assign prod   = PROD_W'($signed({1'b0, pix.src_alpha})) *
                    (PROD_W'($signed({1'b0, src[g]})) - PROD_W'($signed({1'b0, dst[g]})));
    assign mix[g] = dst[g] + prod[2*CH_W-1:CH_W];
  end

  // Select what gets written
  always_comb begin
    res.write_enable = 1'b0;
    res.screen_addr  = '0;
    res.out_ch0      = pix.dst_ch0;
    res.out_ch1      = pix.dst_ch1;
    res.out_ch2      = pix.dst_ch2;
    res.out_ch3      = pix.dst_ch3;
    res.last_texel   = cnt.last;
    if (onscreen) begin
      res.screen_addr = addr_full[ADDR_W-1:0];
      if (cfg.blend_mode == BLEND_OPAQUE) begin
        res.write_enable = 1'b1;
        res.out_ch0      = pix.src_ch0;
        res.out_ch1      = pix.src_ch1;
        res.out_ch2      = pix.src_ch2;
        res.out_ch3      = pix.src_alpha;
      end else if (alpha_full) begin
        res.write_enable = 1'b1;
        res.out_ch0      = pix.src_ch0;
        res.out_ch1      = pix.src_ch1;
        res.out_ch2      = pix.src_ch2;
      end else if (!alpha_zero) begin
        res.write_enable = 1'b1;
        res.out_ch0      = mix[0];
        res.out_ch1      = mix[1];
        res.out_ch2      = mix[2];
      end
    end
  end

endmodule

@@ rtl/clipped_alpha_blit_pixel.sv @@
// Top level of the clipped alpha blitter: config, texel counter, two-register pipeline.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one request per texel in raster
//    order, carrying the texture pixel and the screen pixel at its target.
//  - Result channel (out_valid/out_ready/out_data): one result per request, in
//    order: write flag, linear screen address, four new bytes, last-texel flag.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//    only while the pipeline is empty. Writes never reset the texel counters.
//  - Throughput: one texel per clock while the receiver does not stall; an
//    accepted request goes into the input register, which feeds clip, address
//    multiply and blend logic, which feeds the result register.
//  - Reset (rst_n low, synchronous): registers take their reset values, texel
//    counters return to zero and both pipeline stages empty.
//  - Receiver stall: the result register holds; the input register takes one
//    more request, after which in_ready drops until out_ready returns.
module clipped_alpha_blit_pixel (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cab_pkg::cab_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cab_pkg::cab_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cab_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cab_pkg::*;

  cab_cfg_t cfg;
  cab_cnt_t cnt;
  cab_out_t res;

  logic     s1_valid_r;
  cab_in_t  s1_pix_r;
  cab_cnt_t s1_cnt_r;
  logic     out_valid_r;
  cab_out_t out_data_r;
  logic     in_acc;
  logic     s2_load;

  cab_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cab_texel_cnt u_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (in_acc),
    .cfg   (cfg),
    .cnt   (cnt)
  );

  cab_pixel_calc u_calc (
    .pix (s1_pix_r),
    .cnt (s1_cnt_r),
    .cfg (cfg),
    .res (res)
  );

  // Pipeline flow control
  assign s2_load   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s2_load;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input stage: request plus its texel position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_data;
      s1_cnt_r <= cnt;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  // A full pipeline with a stalled receiver must refuse new requests
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  // An accepted request always occupies the input stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted request lost from input stage");
`endif

endmodule
